@@ rtl/core/otfb_pkg.sv @@
// Package for the odometry telemetry frame builder.
// Holds the drive mode codes, register indexes, frame constants and shared types.
// No dependencies.
package otfb_pkg;

  localparam int FRAME_LENGTH = 24;
  localparam int BODY_BYTES   = FRAME_LENGTH - 2;
  localparam int CHECK_POS    = BODY_BYTES;
  localparam int TAIL_POS     = FRAME_LENGTH - 1;
  localparam int POS_W        = 5;

  // Divider geometry: magnitude bits of the numerator, divisor bits, and
  // how many two-bit steps make up one division.
  localparam int NUM_W     = 28;
  localparam int DEN_W     = 20;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int CNT_W     = 4;
  localparam int SUM_W     = 19;

  // Division by three through a reciprocal: (m * RECIP3) >> RECIP3_SH is
  // exact for magnitudes below 2**17, which covers every omni Y sum.
  localparam int RECIP3    = 43691;
  localparam int RECIP3_SH = 17;
  localparam int PROD_W    = SUM_W + 16;

  localparam int IN_W   = 184;
  localparam int ADDR_W = 5;

  typedef enum logic [1:0] {
    MODE_DIFF  = 2'd0,
    MODE_MECA  = 2'd1,
    MODE_OMNI  = 2'd2,
    MODE_NONE  = 2'd3
  } drive_mode_t;

  typedef enum logic [2:0] {
    REG_DRIVE_MODE = 3'd0,
    REG_WHEEL_SP   = 3'd1,
    REG_AXLE_SP    = 3'd2,
    REG_OMNI_X     = 3'd3,
    REG_TURN_R     = 3'd4,
    REG_HEADER     = 3'd5,
    REG_TAIL       = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_index_t;

  // Words that pass through the pipeline next to the velocity math.
  typedef struct packed {
    logic [15:0] acc_0;
    logic [15:0] acc_1;
    logic [15:0] acc_2;
    logic [15:0] gyr_0;
    logic [15:0] gyr_1;
    logic [15:0] gyr_2;
    logic [15:0] batt;
    logic        stop;
  } side_t;

endpackage

@@ rtl/core/otfb_div.sv @@
// Iterative signed divider with 16-bit saturation, two quotient bits a cycle while step is high.
// Depends on otfb_pkg for the numerator and divisor widths.
module otfb_div
  import otfb_pkg::*;
(
  input  logic                    clk,
  input  logic                    start,
  input  logic                    step,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic        [15:0]      result
);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] dvs;
  logic             neg;
  logic             zero;

  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] quo_next;
  logic [DEN_W:0]   trial;

  // Two restoring steps per cycle, taken into the registers while step is high.
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_next, quo_next[NUM_W-1]};
      quo_next = {quo_next[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DEN_W-1:0];
    end
  end

  // Load the magnitude on start, then iterate.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dvs  <= den;
      neg  <= num[NUM_W-1];
      zero <= (den == '0);
    end else if (step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  // Sign and saturate the finished quotient; a zero divisor gives zero.
  always_comb begin
    if (zero) begin
      result = '0;
    end else if (neg) begin
      if (quo >= NUM_W'(32768)) result = 16'h8000;
      else                      result = 16'(-quo[15:0]);
    end else begin
      if (quo > NUM_W'(32767)) result = 16'h7fff;
      else                     result = quo[15:0];
    end
  end

endmodule

@@ rtl/core/odometry_telemetry_frame_builder.sv @@
// Top level of the odometry telemetry frame builder: register file, velocity
// pipeline, frame buffer and byte serializer. Depends on otfb_pkg, otfb_div.
//
//  channel | dir | handshake               | payload
//  s_*     | in  | s_tvalid / s_tready     | wheels, IMU, battery, stop flag
//  m_*     | out | m_tvalid / m_tready     | one frame byte, tlast on tail
//  apb     | in  | psel, penable, pready   | seven geometry/frame registers
//
// An input beat passes two registered stages (sums, then scaling, divisors and
// the constant-divisor quotients), then two dividers working in parallel on
// the register-divisor velocities, then the frame buffer.
// The serializer sends 24 beats per item; the next item is accepted and computed
// while the current frame drains.
// Reset is synchronous and clears all valid flags and the registers to defaults.
// A stall on m_tready holds the output beat and backs up the pipeline stage by stage.
module odometry_telemetry_frame_builder
  import otfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // wheel_a, wheel_b, wheel_c, wheel_d, accel_x, accel_y, accel_z,
  // gyro_x, gyro_y, gyro_z (16 bits each), battery_mv, stop_flag, zero fill
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // frame_byte
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers.
  drive_mode_t drive_mode;
  logic [15:0] wheel_sp;
  logic [15:0] axle_sp;
  logic [15:0] omni_x;
  logic [15:0] turn_r;
  logic [7:0]  header_byte;
  logic [7:0]  tail_byte;
  reg_index_t  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode  <= MODE_DIFF;
      wheel_sp    <= 16'd500;
      axle_sp     <= 16'd0;
      omni_x      <= 16'd866;
      turn_r      <= 16'd200;
      header_byte <= 8'd123;
      tail_byte   <= 8'd125;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_DRIVE_MODE: drive_mode  <= drive_mode_t'(pwdata[1:0]);
        REG_WHEEL_SP:   wheel_sp    <= pwdata[15:0];
        REG_AXLE_SP:    axle_sp     <= pwdata[15:0];
        REG_OMNI_X:     omni_x      <= pwdata[15:0];
        REG_TURN_R:     turn_r      <= pwdata[15:0];
        REG_HEADER:     header_byte <= pwdata[7:0];
        REG_TAIL:       tail_byte   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_DRIVE_MODE: prdata = {30'd0, drive_mode};
      REG_WHEEL_SP:   prdata = {16'd0, wheel_sp};
      REG_AXLE_SP:    prdata = {16'd0, axle_sp};
      REG_OMNI_X:     prdata = {16'd0, omni_x};
      REG_TURN_R:     prdata = {16'd0, turn_r};
      REG_HEADER:     prdata = {24'd0, header_byte};
      REG_TAIL:       prdata = {24'd0, tail_byte};
      default:        prdata = '0;
    endcase
  end

  // Signs and saturates a quotient magnitude to 16 bits.
  function automatic logic [15:0] sat_q(input logic [SUM_W-1:0] mag, input logic neg);
    if (neg) begin
      if (mag >= SUM_W'(32768)) return 16'h8000;
      return 16'(-mag[15:0]);
    end
    if (mag > SUM_W'(32767)) return 16'h7fff;
    return mag[15:0];
  endfunction

  // Handshake chain, computed from the output side back.
  logic a_valid, b_valid, div_busy, div_done, fb_valid;
  logic a_move, b_move, div_start, fb_load, fb_free, emit;
  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] div_cnt;

  assign emit      = fb_valid && (!m_tvalid || m_tready);
  assign fb_free   = !fb_valid || (emit && pos == POS_W'(TAIL_POS));
  assign fb_load   = div_done && fb_free;
  assign div_start = b_valid && !div_busy && (!div_done || fb_load);
  assign b_move    = div_start;
  assign a_move    = a_valid && (!b_valid || b_move);
  assign s_tready  = !a_valid || a_move;

  // Stage A: mode-dependent wheel sums and the IMU remap.
  logic signed [15:0] wa, wb, wc, wd;
  logic signed [SUM_W-1:0] sx, sy, sz;
  logic signed [SUM_W-1:0] a_sx, a_sy, a_sz;
  drive_mode_t a_mode;
  side_t in_side, a_side, b_side, d_side;

  assign wa = s_tdata[15:0];
  assign wb = s_tdata[31:16];
  assign wc = s_tdata[47:32];
  assign wd = s_tdata[63:48];

  always_comb begin
    in_side.acc_0 = s_tdata[95:80];
    in_side.acc_1 = 16'(-s_tdata[79:64]);
    in_side.acc_2 = s_tdata[111:96];
    in_side.gyr_0 = s_tdata[143:128];
    in_side.gyr_1 = 16'(-s_tdata[127:112]);
    in_side.gyr_2 = s_tdata[176] ? 16'd0 : s_tdata[159:144];
    in_side.batt  = s_tdata[175:160];
    in_side.stop  = s_tdata[176];
  end

  always_comb begin
    unique case (drive_mode)
      MODE_DIFF: begin
        sx = SUM_W'(wa) + SUM_W'(wb);
        sy = '0;
        sz = SUM_W'(wb) - SUM_W'(wa);
      end
      MODE_MECA: begin
        sx = SUM_W'(wa) + SUM_W'(wb) + SUM_W'(wc) + SUM_W'(wd);
        sy = SUM_W'(wa) - SUM_W'(wb) + SUM_W'(wc) - SUM_W'(wd);
        sz = SUM_W'(wc) + SUM_W'(wd) - SUM_W'(wa) - SUM_W'(wb);
      end
      MODE_OMNI: begin
        sx = SUM_W'(wc) - SUM_W'(wb);
        sy = (SUM_W'(wa) <<< 1) - SUM_W'(wb) - SUM_W'(wc);
        sz = SUM_W'(wa) + SUM_W'(wb) + SUM_W'(wc);
      end
      default: begin
        sx = '0;
        sy = '0;
        sz = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      a_sx   <= sx;
      a_sy   <= sy;
      a_sz   <= sz;
      a_mode <= drive_mode;
      a_side <= in_side;
    end
  end

  // Stage B: scale by 1000 where needed, form the divisors, and take the
  // quotients by the constant divisors as magnitudes (truncation toward zero).
  logic signed [NUM_W-1:0] nx, nz, b_nx, b_nz;
  logic [DEN_W-1:0] dx, dz, b_dx, b_dz;
  logic signed [NUM_W-1:0] kx, kz;
  logic [SUM_W-1:0] mag_x, mag_y, qx, qy, b_qx, b_qy;
  logic [PROD_W-1:0] prod_y;
  logic x_div, b_x_div, b_qx_neg, b_qy_neg;

  assign kx     = NUM_W'(a_sx) * NUM_W'(1000);
  assign kz     = NUM_W'(a_sz) * NUM_W'(1000);
  assign mag_x  = a_sx[SUM_W-1] ? SUM_W'(-a_sx) : SUM_W'(a_sx);
  assign mag_y  = a_sy[SUM_W-1] ? SUM_W'(-a_sy) : SUM_W'(a_sy);
  assign prod_y = PROD_W'(mag_y) * PROD_W'(RECIP3);

  always_comb begin
    nx    = '0;
    nz    = kz;
    dx    = DEN_W'(1);
    qx    = '0;
    qy    = '0;
    x_div = 1'b0;
    unique case (a_mode)
      MODE_DIFF: begin
        dz = DEN_W'(wheel_sp);
        qx = mag_x >> 1;
      end
      MODE_MECA: begin
        dz = (DEN_W'(wheel_sp) + DEN_W'(axle_sp)) << 2;
        qx = mag_x >> 2;
        qy = mag_y >> 2;
      end
      MODE_OMNI: begin
        nx    = kx;
        dx    = DEN_W'(omni_x) << 1;
        dz    = DEN_W'(turn_r) * DEN_W'(3);
        qy    = SUM_W'(prod_y >> RECIP3_SH);
        x_div = 1'b1;
      end
      default: begin
        nz = '0;
        dz = DEN_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_valid || b_move) begin
      b_valid <= a_valid;
    end
    if (a_move) begin
      b_nx     <= nx;
      b_nz     <= nz;
      b_dx     <= dx;
      b_dz     <= dz;
      b_qx     <= qx;
      b_qy     <= qy;
      b_qx_neg <= a_sx[SUM_W-1];
      b_qy_neg <= a_sy[SUM_W-1];
      b_x_div  <= x_div;
      b_side   <= a_side;
    end
  end

  // Divider stage: two units in lockstep under one step counter; the
  // constant-divisor results are signed and saturated on the way in.
  logic [15:0] vx_div, vz, vx_sel;
  logic [15:0] d_vx_c, d_vy;
  logic        d_x_div;

  otfb_div u_div_x (.clk, .start(div_start), .step(div_busy), .num(b_nx), .den(b_dx),
                    .result(vx_div));
  otfb_div u_div_z (.clk, .start(div_start), .step(div_busy), .num(b_nz), .den(b_dz),
                    .result(vz));

  assign vx_sel = d_x_div ? vx_div : d_vx_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else if (div_start) begin
      div_busy <= 1'b1;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
        div_busy <= 1'b0;
        div_done <= 1'b1;
      end
    end else if (fb_load) begin
      div_done <= 1'b0;
    end
    if (div_start) begin
      d_side  <= b_side;
      d_vx_c  <= sat_q(b_qx, b_qx_neg);
      d_vy    <= sat_q(b_qy, b_qy_neg);
      d_x_div <= b_x_div;
    end
  end

  // Frame buffer and serializer with a running XOR check.
  logic [7:0] fb [BODY_BYTES];
  logic [7:0] chk;
  logic [7:0] cur_byte;

  always_comb begin
    if (pos < POS_W'(BODY_BYTES))      cur_byte = fb[pos];
    else if (pos == POS_W'(CHECK_POS)) cur_byte = chk;
    else                               cur_byte = tail_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_valid <= 1'b0;
      pos      <= '0;
      chk      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fb_load) begin
        fb_valid <= 1'b1;
        pos      <= '0;
        chk      <= '0;
      end else if (emit) begin
        if (pos == POS_W'(TAIL_POS)) fb_valid <= 1'b0;
        if (pos < POS_W'(BODY_BYTES)) chk <= chk ^ cur_byte;
        pos <= pos + 1'b1;
      end
    end
    if (emit) begin
      m_tdata <= cur_byte;
      m_tlast <= (pos == POS_W'(TAIL_POS));
    end
    if (fb_load) begin
      fb[0]  <= header_byte;
      fb[1]  <= {7'd0, d_side.stop};
      fb[2]  <= vx_sel[15:8];
      fb[3]  <= vx_sel[7:0];
      fb[4]  <= d_vy[15:8];
      fb[5]  <= d_vy[7:0];
      fb[6]  <= vz[15:8];
      fb[7]  <= vz[7:0];
      fb[8]  <= d_side.acc_0[15:8];
      fb[9]  <= d_side.acc_0[7:0];
      fb[10] <= d_side.acc_1[15:8];
      fb[11] <= d_side.acc_1[7:0];
      fb[12] <= d_side.acc_2[15:8];
      fb[13] <= d_side.acc_2[7:0];
      fb[14] <= d_side.gyr_0[15:8];
      fb[15] <= d_side.gyr_0[7:0];
      fb[16] <= d_side.gyr_1[15:8];
      fb[17] <= d_side.gyr_1[7:0];
      fb[18] <= d_side.gyr_2[15:8];
      fb[19] <= d_side.gyr_2[7:0];
      fb[20] <= d_side.batt[15:8];
      fb[21] <= d_side.batt[7:0];
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench for the odometry telemetry frame builder: random and directed
// sensor beats in, 24-byte frames out, checked against a built-in predictor.
// Depends on otfb_pkg and odometry_telemetry_frame_builder.
`timescale 1ns / 1ps

module tb;
  import otfb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // wheel_a, wheel_b, wheel_c, wheel_d, accel_x, accel_y, accel_z,
  // gyro_x, gyro_y, gyro_z, battery_mv, stop_flag, zero fill
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // frame_byte
  logic [7:0] m_tdata;
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  odometry_telemetry_frame_builder dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // Shadow copy of the geometry and frame registers.
  logic [1:0]  sh_mode;
  logic [15:0] sh_track, sh_base, sh_omni_x, sh_radius;
  logic [7:0]  sh_head, sh_tail;

  logic [IN_W-1:0] pending_samples[$];
  frame_beat_t     expected_bytes[$];
  int errors = 0;
  int frames_seen = 0;
  int bytes_seen = 0;
  int samples_sent = 0;
  longint cycles = 0;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch at byte %0d: %s got %h want %h", bytes_seen, what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint quot(input longint n, input longint d);
    if (d == 0) return 0;
    return n / d;
  endfunction

  // Computes the full frame for one sensor beat and queues its bytes.
  task automatic predict_frame(input logic [IN_W-1:0] w);
    longint a, b, c, d, vx, vy, vz;
    logic [7:0] body[BODY_BYTES];
    logic [15:0] words[10];
    logic [7:0] chk;
    logic stop;
    a = longint'($signed(w[15:0]));
    b = longint'($signed(w[31:16]));
    c = longint'($signed(w[47:32]));
    d = longint'($signed(w[63:48]));
    stop = w[176];
    vx = 0; vy = 0; vz = 0;
    case (drive_mode_t'(sh_mode))
      MODE_DIFF: begin
        vx = quot(a + b, 2);
        vz = quot((b - a) * 1000, longint'(sh_track));
      end
      MODE_MECA: begin
        vx = quot(a + b + c + d, 4);
        vy = quot(a - b + c - d, 4);
        vz = quot((-a - b + c + d) * 1000, 4 * (longint'(sh_track) + longint'(sh_base)));
      end
      MODE_OMNI: begin
        vx = quot((c - b) * 1000, 2 * longint'(sh_omni_x));
        vy = quot(2 * a - b - c, 3);
        vz = quot((a + b + c) * 1000, 3 * longint'(sh_radius));
      end
      default: ;
    endcase
    words[0] = clip16(vx);
    words[1] = clip16(vy);
    words[2] = clip16(vz);
    words[3] = w[95:80];
    words[4] = -w[79:64];
    words[5] = w[111:96];
    words[6] = w[143:128];
    words[7] = -w[127:112];
    words[8] = stop ? 16'd0 : w[159:144];
    words[9] = w[175:160];
    body[0] = sh_head;
    body[1] = {7'd0, stop};
    for (int i = 0; i < 10; i++) begin
      body[2 + 2 * i] = words[i][15:8];
      body[3 + 2 * i] = words[i][7:0];
    end
    chk = '0;
    for (int i = 0; i < BODY_BYTES; i++) begin
      chk ^= body[i];
      expected_bytes.push_back('{body[i], 1'b0});
    end
    expected_bytes.push_back('{chk, 1'b0});
    expected_bytes.push_back('{sh_tail, 1'b1});
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] make_sample(input logic [15:0] f[11], input logic stop);
    logic [IN_W-1:0] w;
    w = '0;
    for (int i = 0; i < 11; i++) w[16 * i +: 16] = f[i];
    w[176] = stop;
    return w;
  endfunction

  // Input driver: random gaps, most short and a few long, with gap-free stretches.
  int gap = 0;
  bit burst = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_frame(s_tdata);
        samples_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_samples.pop_front();
          if ($urandom_range(0, 30) == 0) burst <= ~burst;
          if (!burst)
            gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random backpressure.
  int stall = 0;
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          report("unexpected byte", m_tdata, 8'h00);
        end else begin
          frame_beat_t e;
          e = expected_bytes.pop_front();
          if (m_tdata !== e.data) report("frame_byte", m_tdata, e.data);
          if (m_tlast !== e.last) report("last_byte", {7'd0, m_tlast}, {7'd0, e.last});
        end
        bytes_seen++;
        if (m_tlast === 1'b1) frames_seen++;
      end
      if (stall > 0) begin
        stall <= stall - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!burst && $urandom_range(0, 7) == 0)
          stall <= ($urandom_range(0, 12) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      end
    end
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DRIVE_MODE: sh_mode = value[1:0];
      REG_WHEEL_SP:   sh_track = value[15:0];
      REG_AXLE_SP:    sh_base = value[15:0];
      REG_OMNI_X:     sh_omni_x = value[15:0];
      REG_TURN_R:     sh_radius = value[15:0];
      REG_HEADER:     sh_head = value[7:0];
      REG_TAIL:       sh_tail = value[7:0];
      default: ;
    endcase
  endtask

  // Waits until every queued sample has been sent and every frame has drained.
  task automatic drain();
    while (pending_samples.size() > 0 || s_tvalid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    logic [15:0] f[11];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 11; i++) f[i] = rand_word();
      pending_samples.push_back(make_sample(f, 1'($urandom)));
    end
  endtask

  initial begin
    logic [15:0] f[11];
    sh_mode = MODE_DIFF; sh_track = 16'd500; sh_base = 16'd0;
    sh_omni_x = 16'd866; sh_radius = 16'd200; sh_head = 8'd123; sh_tail = 8'd125;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, field extremes, stop on and off, all modes.
    for (int m = 0; m < 4; m++) begin
      if (m > 0) write_reg(REG_DRIVE_MODE, 32'(m));
      for (int i = 0; i < 11; i++) f[i] = 16'h7fff;
      pending_samples.push_back(make_sample(f, 1'b0));
      for (int i = 0; i < 11; i++) f[i] = (i == 1 || i == 2) ? 16'h7fff : 16'h8000;
      pending_samples.push_back(make_sample(f, 1'b1));
      for (int i = 0; i < 11; i++) f[i] = (i % 2) ? 16'h8000 : 16'hffff;
      pending_samples.push_back(make_sample(f, 1'b0));
      for (int i = 0; i < 11; i++) f[i] = 16'h0000;
      pending_samples.push_back(make_sample(f, 1'b1));
      drain();
    end

    // Zero divisors and small geometry with the saturating extremes.
    write_reg(REG_WHEEL_SP, 32'd0);
    write_reg(REG_OMNI_X, 32'd0);
    write_reg(REG_TURN_R, 32'd0);
    for (int m = 0; m < 3; m++) begin
      write_reg(REG_DRIVE_MODE, 32'(m));
      queue_random(2);
      drain();
    end

    // Random phases, each with a fresh register setting.
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_DRIVE_MODE, 32'($urandom_range(0, 3)));
      write_reg(REG_WHEEL_SP, (p == 0) ? 32'hffff : (p == 1) ? 32'd1 : 32'($urandom));
      write_reg(REG_AXLE_SP, (p == 0) ? 32'hffff : (p == 1) ? 32'd0 : 32'($urandom));
      write_reg(REG_OMNI_X, (p == 0) ? 32'hffff : (p == 1) ? 32'd1 : 32'($urandom_range(1, 2000)));
      write_reg(REG_TURN_R, (p == 0) ? 32'hffff : (p == 1) ? 32'd1 : 32'($urandom_range(1, 2000)));
      write_reg(REG_HEADER, (p == 0) ? 32'hff : (p == 1) ? 32'h00 : 32'($urandom));
      write_reg(REG_TAIL, (p == 0) ? 32'h00 : (p == 1) ? 32'hff : 32'($urandom));
      queue_random(20);
      drain();
    end

    $display("sent %0d sensor beats, checked %0d frames (%0d bytes) over all drive modes",
             samples_sent, frames_seen, bytes_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/otfb_pkg.sv
rtl/core/otfb_div.sv
rtl/core/odometry_telemetry_frame_builder.sv
verif/tb.sv
